[rtl/core/sdou_pkg.sv]
// Shared types, constants and helpers of the static/dynamic occupancy update.
// Depends on nothing; sdou_bayes, the top level and the bench import it.
`timescale 1ns / 1ps
package sdou_pkg;

	// Default number of grid cells held in each store.
	localparam int unsigned CELL_COUNT_DEF = 65536;

	// Quotient bits of the odds and the probability dividers.
	localparam int ODDS_STEPS = 24;
	localparam int PROB_STEPS = 16;

	// Register stages of the arithmetic core, from its inputs to its registered outputs.
	localparam int BAYES_LAT = 1 + ODDS_STEPS + 1 + PROB_STEPS + 1 + 1 + 1 + PROB_STEPS + 1;
	// Stages from read data to write back, each of which may hold a cell.
	localparam int TRACK_DEPTH = BAYES_LAT + 1;

	localparam logic [15:0] PROB_HALF  = 16'h8000;
	localparam logic [15:0] PROB_FLOOR = 16'd655;
	localparam logic [15:0] PROB_MAX   = 16'hFFFF;
	localparam logic [23:0] ODDS_MAX   = 24'hFF_FFFF;

	localparam logic [7:0] COST_OCCUPIED = 8'd254;
	localparam logic [7:0] COST_UNKNOWN  = 8'd255;

	// Measurement class of one cost byte.
	typedef enum logic [1:0] {
		MEAS_FREE,
		MEAS_OCC,
		MEAS_UNK
	} meas_t;

	// Register indexes of the configuration port.
	typedef enum logic [2:0] {
		REG_FREE_BOUND,
		REG_OCCUPIED_BOUND,
		REG_STATIC_LOW_ODDS,
		REG_STATIC_HIGH_ODDS,
		REG_STATIC_PROMOTE_ODDS,
		REG_DYNAMIC_LOW_ODDS,
		REG_DYNAMIC_HIGH_ODDS,
		REG_CONFIDENCE
	} reg_idx_t;

	// Configuration handed from the register bank to the arithmetic core.
	typedef struct packed {
		logic [15:0] free_bound;
		logic [15:0] occupied_bound;
		logic [23:0] static_low_odds;
		logic [23:0] static_high_odds;
		logic [23:0] static_promote_odds;
		logic [23:0] dynamic_low_odds;
		logic [23:0] dynamic_high_odds;
		logic [15:0] confidence;
	} cfg_t;

	// Measurement value with 1.0 = 65536.
	function automatic logic [16:0] meas_value(meas_t m);
		logic [16:0] v;
		case (m)
			MEAS_OCC: v = 17'h10000;
			MEAS_UNK: v = 17'h08000;
			default:  v = 17'h00000;
		endcase
		return v;
	endfunction

endpackage

[rtl/core/sdou_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module sdou_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port; a read of the word being written returns old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/sdou_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// Depends on nothing; widths come from its parameters.
`timescale 1ns / 1ps
module sdou_div #(
	parameter int DW = 33,
	parameter int QW = 24,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic [DW-1:0] r_init,
	input  logic [QW-1:0] num_bits,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag_in,
	output logic [QW-1:0] quo,
	output logic [TW-1:0] tag_out
);

	logic [DW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] nb_s  [QW];
	logic [QW-1:0] quo_s [QW];
	logic [TW-1:0] tag_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] nb_in;
		logic [QW-1:0] quo_in;
		logic [TW-1:0] tag_l;
		logic [DW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in = r_init;
			assign den_in = den;
			assign nb_in  = num_bits;
			assign quo_in = '0;
			assign tag_l  = tag_in;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign nb_in  = nb_s[k-1];
			assign quo_in = quo_s[k-1];
			assign tag_l  = tag_s[k-1];
		end

		// Shift in the next numerator bit and subtract the divisor where it fits.
		assign trial = {rem_in, nb_in[QW-1]};
		assign ge    = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
			den_s[k] <= den_in;
			nb_s[k]  <= {nb_in[QW-2:0], 1'b0};
			quo_s[k] <= {quo_in[QW-2:0], ge};
			tag_s[k] <= tag_l;
		end
	end

	assign quo     = quo_s[QW-1];
	assign tag_out = tag_s[QW-1];

endmodule

[rtl/core/sdou_bayes.sv]
// Arithmetic core: odds-form Bayes steps for the static and dynamic probability.
// Depends on sdou_pkg and sdou_div. The pipeline has no stalls.
`timescale 1ns / 1ps
module sdou_bayes (
	input  logic                clk,
	input  logic                action,
	input  sdou_pkg::meas_t     meas,
	input  logic [15:0]         s_old,
	input  logic [15:0]         d_old,
	input  sdou_pkg::cfg_t      cfg,
	output logic [15:0]         s_new,
	output logic [15:0]         d_new
);
	import sdou_pkg::*;

	// Stage 1: discounted probabilities and the static model factor.
	logic [16:0] m_in;
	logic        st_high;
	logic        st_promote;
	logic [31:0] qs_s1;
	logic [31:0] qd_s1;
	logic [23:0] model_s1;
	meas_t       meas_s1;
	logic        act_s1;

	assign m_in       = meas_value(meas);
	assign st_high    = (18'(m_in) + 18'(s_old)) > (18'(cfg.free_bound) + 18'h10000);
	assign st_promote = 18'(m_in) > (18'(s_old) + 18'(cfg.occupied_bound));

	always_ff @(posedge clk) begin
		qs_s1    <= 32'(s_old) * 32'(cfg.confidence);
		qd_s1    <= 32'(d_old) * 32'(cfg.confidence);
		model_s1 <= st_high ? cfg.static_high_odds :
		            (st_promote ? cfg.static_promote_odds : cfg.static_low_odds);
		meas_s1  <= meas;
		act_s1   <= action;
	end

	// Odds dividers: q * 2^16 / (2^32 - q), saturated when the quotient passes 24 bits.
	logic [40:0] sum_s;
	logic [40:0] sum_d;
	logic        sat_s;
	logic        sat_d;
	logic [23:0] oq_s;
	logic [23:0] oq_d;
	logic [27:0] otag_s;
	logic [0:0]  otag_d;

	assign sum_s = {1'b0, qs_s1, 8'h00} + 41'(qs_s1);
	assign sum_d = {1'b0, qd_s1, 8'h00} + 41'(qd_s1);
	assign sat_s = sum_s[40];
	assign sat_d = sum_d[40];

	sdou_div #(.DW(33), .QW(ODDS_STEPS), .TW(28)) u_odds_s (
		.clk      (clk),
		.r_init   (33'(qs_s1[31:8])),
		.num_bits ({qs_s1[7:0], 16'h0000}),
		.den      (33'h1_0000_0000 - 33'(qs_s1)),
		.tag_in   ({sat_s, model_s1, meas_s1, act_s1}),
		.quo      (oq_s),
		.tag_out  (otag_s)
	);

	sdou_div #(.DW(33), .QW(ODDS_STEPS), .TW(1)) u_odds_d (
		.clk      (clk),
		.r_init   (33'(qd_s1[31:8])),
		.num_bits ({qd_s1[7:0], 16'h0000}),
		.den      (33'h1_0000_0000 - 33'(qd_s1)),
		.tag_in   (sat_d),
		.quo      (oq_d),
		.tag_out  (otag_d)
	);

	// Stage 26: static odds product.
	logic [23:0] odds_s;
	logic [23:0] odds_d;
	logic [47:0] x_s26;
	logic [23:0] odds_d_s26;
	meas_t       meas_s26;
	logic        act_s26;

	assign odds_s = otag_s[27] ? ODDS_MAX : oq_s;
	assign odds_d = otag_d[0] ? ODDS_MAX : oq_d;

	always_ff @(posedge clk) begin
		x_s26      <= 48'(otag_s[26:3]) * 48'(odds_s);
		odds_d_s26 <= odds_d;
		meas_s26   <= meas_t'(otag_s[2:1]);
		act_s26    <= otag_s[0];
	end

	// Static probability divider: x * 2^16 / (2^32 + x).
	logic [15:0] pq_s;
	logic [26:0] ptag_s;

	sdou_div #(.DW(49), .QW(PROB_STEPS), .TW(27)) u_prob_s (
		.clk      (clk),
		.r_init   (49'(x_s26)),
		.num_bits (16'h0000),
		.den      (49'h1_0000_0000 + 49'(x_s26)),
		.tag_in   ({odds_d_s26, meas_s26, act_s26}),
		.quo      (pq_s),
		.tag_out  (ptag_s)
	);

	// Stage 43: final static value, floored, with load and unknown overrides.
	meas_t       meas_p;
	logic [15:0] s_fin;
	logic [15:0] s_s43;
	logic [23:0] odds_d_s43;
	meas_t       meas_s43;
	logic        act_s43;

	assign meas_p = meas_t'(ptag_s[2:1]);

	always_comb begin
		if (!ptag_s[0]) begin
			case (meas_p)
				MEAS_OCC: s_fin = PROB_MAX;
				MEAS_UNK: s_fin = PROB_HALF;
				default:  s_fin = '0;
			endcase
		end else if (meas_p == MEAS_UNK) begin
			s_fin = PROB_HALF;
		end else begin
			s_fin = (pq_s < PROB_FLOOR) ? PROB_FLOOR : pq_s;
		end
	end

	always_ff @(posedge clk) begin
		s_s43      <= s_fin;
		odds_d_s43 <= ptag_s[26:3];
		meas_s43   <= meas_p;
		act_s43    <= ptag_s[0];
	end

	// Stage 44: dynamic model factor, tested against the new static value.
	logic        dyn_believe;
	logic [23:0] model_d_s44;
	logic [23:0] odds_d_s44;
	logic [15:0] s_s44;
	logic        act_s44;

	assign dyn_believe = 18'(meas_value(meas_s43)) > (18'(s_s43) + 18'(cfg.occupied_bound));

	always_ff @(posedge clk) begin
		model_d_s44 <= dyn_believe ? cfg.dynamic_high_odds : cfg.dynamic_low_odds;
		odds_d_s44  <= odds_d_s43;
		s_s44       <= s_s43;
		act_s44     <= act_s43;
	end

	// Stage 45: dynamic odds product.
	logic [47:0] x_s45;
	logic [15:0] s_s45;
	logic        act_s45;

	always_ff @(posedge clk) begin
		x_s45   <= 48'(model_d_s44) * 48'(odds_d_s44);
		s_s45   <= s_s44;
		act_s45 <= act_s44;
	end

	// Dynamic probability divider.
	logic [15:0] pq_d;
	logic [16:0] ptag_d;

	sdou_div #(.DW(49), .QW(PROB_STEPS), .TW(17)) u_prob_d (
		.clk      (clk),
		.r_init   (49'(x_s45)),
		.num_bits (16'h0000),
		.den      (49'h1_0000_0000 + 49'(x_s45)),
		.tag_in   ({s_s45, act_s45}),
		.quo      (pq_d),
		.tag_out  (ptag_d)
	);

	// Stage 62: both results registered.
	logic [15:0] s_s62;
	logic [15:0] d_s62;

	always_ff @(posedge clk) begin
		s_s62 <= ptag_d[16:1];
		d_s62 <= !ptag_d[0] ? PROB_HALF : ((pq_d < PROB_FLOOR) ? PROB_FLOOR : pq_d);
	end

	assign s_new = s_s62;
	assign d_new = d_s62;

endmodule

[rtl/core/static_dynamic_occupancy_update.sv]
// Static/dynamic occupancy update: one cell word in, one result word out per item.
// An item passes the front stages, the store read and the arithmetic core; its result word shows on the strobe.
// Throughput: one item per cycle; an item whose cell is still in the 63-stage
// read-to-write-back window waits (busy high) until that cell has been written.
// Reset: the configuration registers take their defaults, then a clearing pass writes one half into
// every cell of both stores with busy high. Results cannot be stalled.
`timescale 1ns / 1ps
module static_dynamic_occupancy_update #(
	parameter int unsigned CELL_COUNT = sdou_pkg::CELL_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [15:0] cell_index,
	input  logic [7:0]  cost,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output logic        strobe,
	output logic [15:0] cell_index_out,
	output logic [15:0] static_prob,
	output logic [15:0] dynamic_prob,
	output logic [6:0]  static_percent,
	output logic [6:0]  dynamic_percent
);
	import sdou_pkg::*;

	localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

	// Configuration registers.
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.free_bound          <= 16'd6554;
			cfg_q.occupied_bound      <= 16'd58982;
			cfg_q.static_low_odds     <= 24'd43691;
			cfg_q.static_high_odds    <= 24'd589824;
			cfg_q.static_promote_odds <= 24'd70997;
			cfg_q.dynamic_low_odds    <= 24'd16384;
			cfg_q.dynamic_high_odds   <= 24'd6488064;
			cfg_q.confidence          <= 16'd64881;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FREE_BOUND:          cfg_q.free_bound          <= cfg_data[15:0];
				REG_OCCUPIED_BOUND:      cfg_q.occupied_bound      <= cfg_data[15:0];
				REG_STATIC_LOW_ODDS:     cfg_q.static_low_odds     <= cfg_data;
				REG_STATIC_HIGH_ODDS:    cfg_q.static_high_odds    <= cfg_data;
				REG_STATIC_PROMOTE_ODDS: cfg_q.static_promote_odds <= cfg_data;
				REG_DYNAMIC_LOW_ODDS:    cfg_q.dynamic_low_odds    <= cfg_data;
				REG_DYNAMIC_HIGH_ODDS:   cfg_q.dynamic_high_odds   <= cfg_data;
				REG_CONFIDENCE:          cfg_q.confidence          <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Clearing pass after reset.
	logic          clr_active_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			if (clr_addr_q == AW'(CELL_COUNT - 1)) begin
				clr_active_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Front pipeline: accept, index reduction, read issue. It holds as one on a cell conflict.
	logic          hold;
	logic          front_en;
	logic          accept;
	logic          val_s1;
	logic          act_s1;
	logic [15:0]   idx_s1;
	logic [7:0]    cost_s1;
	logic          val_s2;
	logic          act_s2;
	logic [7:0]    cost_s2;
	logic [AW-1:0] cell_s2;
	logic          val_s3;
	logic          act_s3;
	logic [AW-1:0] cell_s3;
	meas_t         meas_s3;
	meas_t         meas_next;

	assign front_en = !hold;
	assign busy     = clr_active_q || hold;
	assign accept   = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
			val_s2 <= 1'b0;
			val_s3 <= 1'b0;
		end else if (front_en) begin
			val_s1 <= accept;
			val_s2 <= val_s1;
			val_s3 <= val_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (front_en) begin
			act_s1  <= action;
			idx_s1  <= cell_index;
			cost_s1 <= cost;
			act_s2  <= act_s1;
			cost_s2 <= cost_s1;
			act_s3  <= act_s2;
			cell_s3 <= cell_s2;
			meas_s3 <= meas_next;
		end
	end

	// Cell index reduced modulo the store depth.
	if (CELL_COUNT >= 65536) begin : g_no_wrap
		logic [15:0] idx_s2;

		always_ff @(posedge clk) begin
			if (front_en) begin
				idx_s2 <= idx_s1;
			end
		end

		assign cell_s2 = AW'(idx_s2);
	end else begin : g_wrap
		localparam logic [32:0] RECIP =
			33'(((64'd1 << 32) + 64'(CELL_COUNT) - 64'd1) / 64'(CELL_COUNT));
		logic [15:0] idx_s2;
		logic [48:0] prod_s2;
		logic [32:0] qc;

		// Quotient by reciprocal multiply; exact for 16-bit indexes.
		always_ff @(posedge clk) begin
			if (front_en) begin
				idx_s2  <= idx_s1;
				prod_s2 <= 49'(idx_s1) * 49'(RECIP);
			end
		end

		assign qc      = 33'(prod_s2[48:32]) * 33'(CELL_COUNT);
		assign cell_s2 = AW'(idx_s2 - qc[15:0]);
	end

	// Cost byte to measurement class.
	always_comb begin
		case (cost_s2)
			COST_OCCUPIED: meas_next = MEAS_OCC;
			COST_UNKNOWN:  meas_next = MEAS_UNK;
			default:       meas_next = MEAS_FREE;
		endcase
	end

	// Cells in flight from read data to write back.
	logic          trk_valid_q [TRACK_DEPTH];
	logic [AW-1:0] trk_cell_q  [TRACK_DEPTH];
	logic [TRACK_DEPTH-1:0] hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TRACK_DEPTH; i++) begin
				trk_valid_q[i] <= 1'b0;
			end
		end else begin
			trk_valid_q[0] <= val_s3 && front_en;
			for (int i = 1; i < TRACK_DEPTH; i++) begin
				trk_valid_q[i] <= trk_valid_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		trk_cell_q[0] <= cell_s3;
		for (int i = 1; i < TRACK_DEPTH; i++) begin
			trk_cell_q[i] <= trk_cell_q[i-1];
		end
	end

	// An item waits while its cell has a read-modify-write still open.
	always_comb begin
		for (int i = 0; i < TRACK_DEPTH; i++) begin
			hit[i] = trk_valid_q[i] && (trk_cell_q[i] == cell_s3);
		end
	end

	assign hold = val_s3 && (|hit);

	// Item fields next to the read data.
	logic  act_s4;
	meas_t meas_s4;

	always_ff @(posedge clk) begin
		act_s4  <= act_s3;
		meas_s4 <= meas_s3;
	end

	// Stores and their shared write port.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   s_wdata;
	logic [15:0]   d_wdata;
	logic [15:0]   s_rdata;
	logic [15:0]   d_rdata;
	logic [15:0]   s_res;
	logic [15:0]   d_res;
	logic          wb_valid;
	logic [AW-1:0] wb_cell;

	assign wb_valid  = trk_valid_q[TRACK_DEPTH-1];
	assign wb_cell   = trk_cell_q[TRACK_DEPTH-1];
	assign ram_we    = clr_active_q || wb_valid;
	assign ram_waddr = clr_active_q ? clr_addr_q : wb_cell;
	assign s_wdata   = clr_active_q ? PROB_HALF : s_res;
	assign d_wdata   = clr_active_q ? PROB_HALF : d_res;

	sdou_ram #(.WIDTH(16), .DEPTH(CELL_COUNT), .AW(AW)) u_static_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (s_wdata),
		.raddr (cell_s3),
		.rdata (s_rdata)
	);

	sdou_ram #(.WIDTH(16), .DEPTH(CELL_COUNT), .AW(AW)) u_dynamic_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (d_wdata),
		.raddr (cell_s3),
		.rdata (d_rdata)
	);

	// Arithmetic core.
	sdou_bayes u_bayes (
		.clk    (clk),
		.action (act_s4),
		.meas   (meas_s4),
		.s_old  (s_rdata),
		.d_old  (d_rdata),
		.cfg    (cfg_q),
		.s_new  (s_res),
		.d_new  (d_res)
	);

	// Percents and the clamp limit.
	logic [22:0] s_pct_full;
	logic [22:0] d_pct_full;
	logic [23:0] limit_full;
	logic [6:0]  s_pct;

	assign s_pct_full = 23'(s_res) * 23'd100;
	assign d_pct_full = 23'(d_res) * 23'd100;
	assign limit_full = 24'(cfg_q.occupied_bound) * 24'd100 + 24'd32768;
	assign s_pct      = ({1'b0, s_pct_full[22:16]} > limit_full[23:16]) ? 7'd100
	                                                                     : s_pct_full[22:16];

	// Result word register.
	logic strobe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= wb_valid;
		end
	end

	always_ff @(posedge clk) begin
		cell_index_out  <= 16'(wb_cell);
		static_prob     <= s_res;
		dynamic_prob    <= d_res;
		static_percent  <= s_pct;
		dynamic_percent <= d_pct_full[22:16];
	end

	assign strobe = strobe_q;

endmodule

[rtl/core/sdou_chk.sv]
// Port-level checks of the occupancy update block, bound to its top level.
// Depends on static_dynamic_occupancy_update for the bind target.
`timescale 1ns / 1ps
module sdou_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        busy,
	input logic        strobe,
	input logic [15:0] dynamic_prob,
	input logic [6:0]  static_percent,
	input logic [6:0]  dynamic_percent
);

	// The clearing pass keeps the block busy right after reset.
	a_busy_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> busy)
		else $error("block not busy right after reset");

	// Percents never exceed one hundred.
	a_percent_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (static_percent <= 7'd100) && (dynamic_percent <= 7'd100))
		else $error("percent out of range");

	// The dynamic probability is floored or one half on load.
	a_dynamic_floor: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> dynamic_prob >= 16'd655)
		else $error("dynamic probability below floor");

endmodule

bind static_dynamic_occupancy_update sdou_chk u_sdou_chk (.*);

[verif/tb.sv]
// Self-checking bench for the static/dynamic occupancy update block.
// Depends on sdou_pkg and static_dynamic_occupancy_update; models both cell stores.
`timescale 1ns / 1ps
module tb;
	import sdou_pkg::*;

	// One result word as the block should deliver it.
	typedef struct {
		logic [15:0] idx;
		logic [15:0] sprob;
		logic [15:0] dprob;
		logic [6:0]  spct;
		logic [6:0]  dpct;
	} cell_word_t;

	// Occupancy model with its own copy of the registers and both stores.
	class occupancy_board;
		logic [23:0] regs [8];
		logic [15:0] static_cells [65536];
		logic [15:0] dynamic_cells [65536];
		cell_word_t  pending [$];
		int          errors;

		function new();
			for (int i = 0; i < 65536; i++) begin
				static_cells[i] = PROB_HALF;
				dynamic_cells[i] = PROB_HALF;
			end
			regs[REG_FREE_BOUND] = 6554;
			regs[REG_OCCUPIED_BOUND] = 58982;
			regs[REG_STATIC_LOW_ODDS] = 43691;
			regs[REG_STATIC_HIGH_ODDS] = 589824;
			regs[REG_STATIC_PROMOTE_ODDS] = 70997;
			regs[REG_DYNAMIC_LOW_ODDS] = 16384;
			regs[REG_DYNAMIC_HIGH_ODDS] = 6488064;
			regs[REG_CONFIDENCE] = 64881;
			errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [23:0] v);
			if (idx == REG_FREE_BOUND || idx == REG_OCCUPIED_BOUND || idx == REG_CONFIDENCE)
				regs[idx] = {8'd0, v[15:0]};
			else
				regs[idx] = v;
		endfunction

		// Discount, convert to odds, apply the model factor and convert back.
		function logic [15:0] odds_step(logic [15:0] p, logic [23:0] factor);
			logic [63:0] q;
			logic [63:0] odds;
			logic [79:0] x;
			logic [79:0] r;
			q = {48'd0, p} * {48'd0, regs[REG_CONFIDENCE][15:0]};
			odds = (q << 16) / (64'h1_0000_0000 - q);
			if (odds > 64'hFF_FFFF)
				odds = 64'hFF_FFFF;
			x = {56'd0, factor} * {16'd0, odds};
			r = (x << 16) / (80'h1_0000_0000 + x);
			if (r < PROB_FLOOR)
				r = PROB_FLOOR;
			if (r > 80'hFFFF)
				r = 80'hFFFF;
			return r[15:0];
		endfunction

		// Work out the result word of an accepted input word and update the stores.
		function void note_word(logic act, logic [15:0] cidx, logic [7:0] cost);
			meas_t       mc;
			int unsigned m, s, d, sp, lim;
			logic [23:0] factor;
			cell_word_t  w;
			mc = (cost == COST_OCCUPIED) ? MEAS_OCC :
				(cost == COST_UNKNOWN) ? MEAS_UNK : MEAS_FREE;
			m = (mc == MEAS_OCC) ? 65536 : (mc == MEAS_UNK) ? 32768 : 0;
			s = static_cells[cidx];
			d = dynamic_cells[cidx];
			if (!act) begin
				s = (m > 65535) ? 65535 : m;
				d = 32768;
			end else begin
				if (m + s > regs[REG_FREE_BOUND] + 65536) begin
					factor = regs[REG_STATIC_HIGH_ODDS];
				end else begin
					factor = regs[REG_STATIC_LOW_ODDS];
					if (m > s + regs[REG_OCCUPIED_BOUND])
						factor = regs[REG_STATIC_PROMOTE_ODDS];
				end
				if (mc == MEAS_UNK)
					s = 32768;
				else
					s = odds_step(s[15:0], factor);
				factor = (m > s + regs[REG_OCCUPIED_BOUND]) ?
					regs[REG_DYNAMIC_HIGH_ODDS] : regs[REG_DYNAMIC_LOW_ODDS];
				d = odds_step(d[15:0], factor);
			end
			static_cells[cidx] = s[15:0];
			dynamic_cells[cidx] = d[15:0];
			sp = (s * 100) >> 16;
			lim = (regs[REG_OCCUPIED_BOUND] * 100 + 32768) >> 16;
			if (sp > lim)
				sp = 100;
			w.idx = cidx;
			w.sprob = s[15:0];
			w.dprob = d[15:0];
			w.spct = sp[6:0];
			w.dpct = 7'((d * 100) >> 16);
			pending.push_back(w);
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		// Compare one delivered word with the oldest expectation.
		task check_word(cell_word_t got);
			cell_word_t e;
			if (pending.size() == 0) begin
				report($sformatf("unexpected word for cell %0d", got.idx));
			end else begin
				e = pending.pop_front();
				if (got.idx !== e.idx)
					report($sformatf("cell %0d, expected %0d", got.idx, e.idx));
				if (got.sprob !== e.sprob)
					report($sformatf("cell %0d static %0d, expected %0d", e.idx, got.sprob, e.sprob));
				if (got.dprob !== e.dprob)
					report($sformatf("cell %0d dynamic %0d, expected %0d", e.idx, got.dprob, e.dprob));
				if (got.spct !== e.spct)
					report($sformatf("cell %0d static pct %0d, expected %0d", e.idx, got.spct, e.spct));
				if (got.dpct !== e.dpct)
					report($sformatf("cell %0d dynamic pct %0d, expected %0d", e.idx, got.dpct, e.dpct));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        action;
	logic [15:0] cell_index;
	logic [7:0]  cost;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;
	logic        strobe;
	logic [15:0] cell_index_out;
	logic [15:0] static_prob;
	logic [15:0] dynamic_prob;
	logic [6:0]  static_percent;
	logic [6:0]  dynamic_percent;

	occupancy_board board;
	logic           quiet;
	logic [15:0]    hot_cells [32];

	static_dynamic_occupancy_update dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .cell_index(cell_index), .cost(cost),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.strobe(strobe), .cell_index_out(cell_index_out), .static_prob(static_prob),
		.dynamic_prob(dynamic_prob), .static_percent(static_percent),
		.dynamic_percent(dynamic_percent)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Collect each word on the strobe.
	always @(posedge clk) begin
		cell_word_t got;
		if (arst_n && strobe) begin
			got.idx = cell_index_out;
			got.sprob = static_prob;
			got.dprob = dynamic_prob;
			got.spct = static_percent;
			got.dpct = dynamic_percent;
			board.check_word(got);
		end
	end

	// Present one word and hold it until the block takes it; start stays high after.
	task send_word(logic act, logic [15:0] cidx, logic [7:0] c);
		start <= 1'b1;
		action <= act;
		cell_index <= cidx;
		cost <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_word(act, cidx, c);
	endtask

	// Random idle burst on the input side, skipped in the quiet tail.
	task maybe_idle();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 13))
				@(posedge clk);
		end
	endtask

	// Let every pending word drain, then give the pipeline its full latency.
	task drain();
		start <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (80)
			@(posedge clk);
	endtask

	// Write all registers back to back; the write enable drops after the last one.
	task write_regs(logic [23:0] vals [8]);
		for (int i = 0; i < 8; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			board.set_reg(reg_idx_t'(i), vals[i]);
		end
		cfg_write <= 1'b0;
	endtask

	// Mostly recurring cells with realistic costs, with some full-range noise.
	task random_word();
		logic [15:0] cidx;
		logic [7:0]  c;
		logic        act;
		int          pick;
		cidx = ($urandom_range(0, 4) == 0) ? 16'($urandom) : hot_cells[$urandom_range(0, 31)];
		pick = $urandom_range(0, 9);
		c = (pick < 3) ? COST_OCCUPIED : (pick < 4) ? COST_UNKNOWN :
			(pick < 7) ? 8'd0 : 8'($urandom);
		act = ($urandom_range(0, 9) != 0);
		send_word(act, cidx, c);
		maybe_idle();
	endtask

	initial begin
		logic [23:0] vals [8];
		logic [23:0] defs [8];
		board = new();
		for (int i = 0; i < 8; i++)
			defs[i] = board.regs[i];
		for (int i = 0; i < 32; i++)
			hot_cells[i] = 16'($urandom);
		hot_cells[0] = 16'h0000;
		hot_cells[1] = 16'hFFFF;
		quiet = 1'b0;
		start = 1'b0;
		action = 1'b0;
		cell_index = 16'd0;
		cost = 8'd0;
		cfg_write = 1'b0;
		cfg_index = REG_FREE_BOUND;
		cfg_data = 24'd0;
		arst_n = 1'b0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under reset defaults: loads, promotion, belief, unknown, floor.
		send_word(1'b0, 16'h0000, 8'd0);
		send_word(1'b0, 16'hFFFF, COST_OCCUPIED);
		send_word(1'b0, 16'd5, COST_UNKNOWN);
		send_word(1'b1, 16'h0000, COST_OCCUPIED);
		send_word(1'b1, 16'hFFFF, COST_OCCUPIED);
		send_word(1'b1, 16'hFFFF, 8'd0);
		send_word(1'b1, 16'd5, COST_UNKNOWN);
		send_word(1'b1, 16'd5, 8'd253);
		send_word(1'b1, 16'hAAAA, 8'd1);
		send_word(1'b1, 16'h5555, 8'd128);
		for (int i = 0; i < 6; i++)
			send_word(1'b1, 16'd7, 8'd0);
		for (int i = 0; i < 5; i++)
			send_word(1'b1, 16'd9, COST_OCCUPIED);
		send_word(1'b1, 16'd9, COST_UNKNOWN);
		send_word(1'b1, 16'd9, 8'd127);
		for (int n = 0; n < 260; n++)
			random_word();
		drain();

		// Further phases: largest values, zeros, then varied settings; last one without gaps.
		for (int ph = 1; ph <= 7; ph++) begin
			for (int i = 0; i < 8; i++) begin
				if (ph == 1)
					vals[i] = 24'hFF_FFFF;
				else if (ph == 2)
					vals[i] = 24'd0;
				else if ($urandom_range(0, 3) == 0)
					vals[i] = 24'($urandom);
				else
					vals[i] = 24'((longint'(defs[i]) * $urandom_range(50, 200)) / 100);
			end
			write_regs(vals);
			quiet = (ph == 7);
			for (int n = 0; n < 235; n++)
				random_word();
			drain();
		end

		if (board.errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	// Watchdog over clearing pass, hazard stalls and idle bursts with wide margin.
	initial begin
		#6000000;
		$display("tb: errors");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/sdou_pkg.sv
rtl/core/sdou_ram.sv
rtl/core/sdou_div.sv
rtl/core/sdou_bayes.sv
rtl/core/static_dynamic_occupancy_update.sv
rtl/core/sdou_chk.sv
verif/tb.sv
